// ===== hw/rtl/xxhash64_stream_top_defines.svh =====
// Assertion macros for the xxhash64 stream block.
// No dependencies; included by the modules that carry assertions.
`ifndef XXHASH64_STREAM_TOP_DEFINES_SVH
`define XXHASH64_STREAM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define XH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define XH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define XH_ASSERT(label, clk, rst_n, prop)
`define XH_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hw/rtl/xxh_pkg.sv =====
// Package for the xxhash64 stream block: primes, command and status types.
// No dependencies.
package xxh_pkg;
  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  // Final phase of a 64x64 multiply built from three 32x32 partial products.
  localparam logic [1:0] MUL_LAST = 2'd2;

  // Datapath operations; multiply ops are held through their partial product phases.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // store word into stripe buffer, bump fill/length
    OP_MUL_A,    // t = x * P2 (x = stripe word or lane)
    OP_ROT_B,    // t = rotl(acc + t, 31) for absorb / rotl(t,31) for merge
    OP_MUL_C,    // lane = t * P1 or t*P1 merge prep
    OP_MERGE0,   // h = sum of rotated lanes
    OP_MERGE1,   // h = (h ^ t) * P1 + P4
    OP_SHORT,    // h = lane2 + P5
    OP_ADDLEN,   // h += total length
    OP_W8,       // h = rotl(h ^ t, 27) * P1 + P4
    OP_W4A,      // t = low32(tail) * P1
    OP_W4B,      // h = rotl(h ^ t, 23) * P2 + P3
    OP_B1A,      // t = byte * P5
    OP_B1B,      // h = rotl(h ^ t, 11) * P1
    OP_AVAL,     // one avalanche step
    OP_DONE      // clear fill and length, reload lanes
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;   // lane / word index
    logic [2:0] step;  // avalanche step, or bit 0 selects the merge variant
    logic [1:0] mph;   // partial product phase of a multiply
  } cmd_t;

  typedef struct packed {
    logic       long_msg;
    logic [5:0] fill;
    logic       idle_msg;  // no bytes since last hash
  } stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
    rotl = (v << r) | (v >> (64 - r));
  endfunction
endpackage

// ===== hw/rtl/xxh_datapath.sv =====
// Datapath for the xxhash64 stream block: lanes, stripe buffer, hash register.
// Depends on xxh_pkg.
module xxh_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xxh_pkg::cmd_t     cmd_i,
  input  logic [63:0]       word_i,
  input  logic [3:0]        count_i,
  input  logic [63:0]       seed_i,
  input  logic              seed_load_i,
  output xxh_pkg::stat_t    stat_o,
  output logic [63:0]       hash_o
);
  logic [63:0] lane_q [4];
  logic [63:0] lane_d [4];
  logic [63:0] buf_q [4];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [63:0] h_q, h_d, t_q, t_d, tail_q, tail_d;
  logic [63:0] mul_a, mul_b, prod;
  logic [31:0] mop_a, mop_b;
  logic [63:0] mprod;
  logic [63:0] pp_q;
  logic [31:0] cross_q;
  logic        mul_fin;
  logic [1:0]  widx;

  // Low 64 bits of mul_a * mul_b in phases: low x low, then the two
  // cross terms, of which only the low halves reach the result.
  assign mul_fin = (cmd_i.mph == xxh_pkg::MUL_LAST);

  always_comb begin
    case (cmd_i.mph)
      2'd0: begin
        mop_a = mul_a[31:0];
        mop_b = mul_b[31:0];
      end
      2'd1: begin
        mop_a = mul_a[31:0];
        mop_b = mul_b[63:32];
      end
      default: begin
        mop_a = mul_a[63:32];
        mop_b = mul_b[31:0];
      end
    endcase
  end

  assign mprod = 64'(mop_a) * 64'(mop_b);
  assign prod  = pp_q + {cross_q + mprod[31:0], 32'd0};
  assign widx  = fill_q[4:3];

  always_comb begin
    mul_a = t_q;
    mul_b = xxh_pkg::P1;
    case (cmd_i.op)
      xxh_pkg::OP_MUL_A: begin
        mul_a = cmd_i.step[0] ? lane_q[cmd_i.sel] : buf_q[cmd_i.sel];
        mul_b = xxh_pkg::P2;
      end
      xxh_pkg::OP_MUL_C: mul_a = t_q;
      xxh_pkg::OP_MERGE1: mul_a = h_q ^ t_q;
      xxh_pkg::OP_W8: mul_a = xxh_pkg::rotl(h_q ^ t_q, 27);
      xxh_pkg::OP_W4A: mul_a = {32'd0, tail_q[31:0]};
      xxh_pkg::OP_W4B: begin
        mul_a = xxh_pkg::rotl(h_q ^ t_q, 23);
        mul_b = xxh_pkg::P2;
      end
      xxh_pkg::OP_B1A: begin
        mul_a = {56'd0, tail_q[7:0]};
        mul_b = xxh_pkg::P5;
      end
      xxh_pkg::OP_B1B: mul_a = xxh_pkg::rotl(h_q ^ t_q, 11);
      xxh_pkg::OP_AVAL: begin
        mul_a = h_q;
        mul_b = (cmd_i.step == 3'd1) ? xxh_pkg::P2 : xxh_pkg::P3;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) lane_d[i] = lane_q[i];
    fill_d = fill_q;
    len_d  = len_q;
    h_d    = h_q;
    t_d    = t_q;
    tail_d = tail_q;
    case (cmd_i.op)
      xxh_pkg::OP_LOAD: begin
        fill_d = fill_q + {2'd0, count_i};
        len_d  = len_q + {60'd0, count_i};
      end
      xxh_pkg::OP_MUL_A: if (mul_fin) t_d = prod;
      xxh_pkg::OP_ROT_B: begin
        if (cmd_i.step[0]) t_d = xxh_pkg::rotl(t_q, 31);
        else t_d = xxh_pkg::rotl(lane_q[cmd_i.sel] + t_q, 31);
      end
      xxh_pkg::OP_MUL_C: if (mul_fin) begin
        if (cmd_i.step[0]) t_d = prod;
        else begin
          lane_d[cmd_i.sel] = prod;
          if (cmd_i.sel == 2'd3) fill_d = '0;
        end
      end
      xxh_pkg::OP_MERGE0:
        h_d = xxh_pkg::rotl(lane_q[0], 1) + xxh_pkg::rotl(lane_q[1], 7)
            + xxh_pkg::rotl(lane_q[2], 12) + xxh_pkg::rotl(lane_q[3], 18);
      xxh_pkg::OP_MERGE1: if (mul_fin) h_d = prod + xxh_pkg::P4;
      xxh_pkg::OP_SHORT: h_d = lane_q[2] + xxh_pkg::P5;
      xxh_pkg::OP_ADDLEN: begin
        h_d = h_q + len_q;
        tail_d = buf_q[widx];
      end
      xxh_pkg::OP_W8: if (mul_fin) h_d = prod + xxh_pkg::P4;
      xxh_pkg::OP_W4A: if (mul_fin) t_d = prod;
      xxh_pkg::OP_W4B: if (mul_fin) begin
        h_d = prod + xxh_pkg::P3;
        tail_d = {32'd0, tail_q[63:32]};
      end
      xxh_pkg::OP_B1A: if (mul_fin) t_d = prod;
      xxh_pkg::OP_B1B: if (mul_fin) begin
        h_d = prod;
        tail_d = {8'd0, tail_q[63:8]};
      end
      xxh_pkg::OP_AVAL: begin
        case (cmd_i.step)
          3'd0: h_d = h_q ^ (h_q >> 33);
          3'd1: if (mul_fin) h_d = prod;
          3'd2: h_d = h_q ^ (h_q >> 29);
          3'd3: if (mul_fin) h_d = prod;
          default: h_d = h_q ^ (h_q >> 32);
        endcase
      end
      xxh_pkg::OP_DONE: begin
        fill_d = '0;
        len_d  = '0;
      end
      default: ;
    endcase
    if (seed_load_i) begin
      lane_d[0] = seed_i + xxh_pkg::P1 + xxh_pkg::P2;
      lane_d[1] = seed_i + xxh_pkg::P2;
      lane_d[2] = seed_i;
      lane_d[3] = seed_i - xxh_pkg::P1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      lane_q[0] <= xxh_pkg::P1 + xxh_pkg::P2;
      lane_q[1] <= xxh_pkg::P2;
      lane_q[2] <= '0;
      lane_q[3] <= '0 - xxh_pkg::P1;
    end else begin
      fill_q <= fill_d;
      len_q  <= len_d;
      for (int i = 0; i < 4; i++) lane_q[i] <= lane_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    t_q    <= t_d;
    tail_q <= tail_d;
    if (cmd_i.mph == 2'd0) pp_q <= mprod;
    if (cmd_i.mph == 2'd1) cross_q <= mprod[31:0];
    if (cmd_i.op == xxh_pkg::OP_LOAD && count_i != 4'd0) buf_q[widx] <= word_i;
  end

  assign stat_o.long_msg    = (len_q >= 64'd32);
  assign stat_o.fill        = fill_q;
  assign stat_o.idle_msg    = (len_q == 64'd0) && (fill_q == 6'd0);
  assign hash_o = h_q;
endmodule

// ===== hw/rtl/xxh_ctrl.sv =====
// Controller for the xxhash64 stream block: sequences datapath operations.
// Depends on xxh_pkg and the assertion macro header.
`include "xxhash64_stream_top_defines.svh"
module xxh_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            last_i,
  input  logic [3:0]      count_i,
  output logic [3:0]      count_o,
  output logic            out_valid,
  input  logic            out_stall,
  input  xxh_pkg::stat_t  stat_i,
  output xxh_pkg::cmd_t   cmd_o,
  output logic            seed_load_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_ABS, S_FIN, S_MRG, S_LEN, S_W8, S_W4, S_B1, S_AVAL, S_DONE, S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] idx_q;
  logic [1:0] ph_q;
  logic [2:0] step_q;
  logic [1:0] words_q;
  logic [2:0] rest_q;
  logic [1:0] mph_q;
  logic       last_q;
  logic       out_valid_q;
  logic       take;
  logic       mul_op;
  logic       adv;
  logic [3:0] cnt;

  assign in_stall = (state_q != S_IDLE);
  assign take = in_valid && !in_stall;
  // Saturate to a full word unless this is a short last word.
  assign cnt = (!last_i || count_i > 4'd8) ? 4'd8 : count_i;
  assign count_o = cnt;
  assign out_valid = out_valid_q;
  assign seed_load_o = (state_q == S_DONE);

  always_comb begin
    cmd_o = '{op: xxh_pkg::OP_NONE, sel: idx_q, step: step_q, mph: mph_q};
    case (state_q)
      S_IDLE: if (take) cmd_o.op = xxh_pkg::OP_LOAD;
      S_ABS: begin
        cmd_o.step = 3'd0;
        case (ph_q)
          2'd0: cmd_o.op = xxh_pkg::OP_MUL_A;
          2'd1: cmd_o.op = xxh_pkg::OP_ROT_B;
          default: cmd_o.op = xxh_pkg::OP_MUL_C;
        endcase
      end
      S_FIN: cmd_o.op = stat_i.long_msg ? xxh_pkg::OP_MERGE0 : xxh_pkg::OP_SHORT;
      S_MRG: begin
        cmd_o.step = 3'd1;
        case (ph_q)
          2'd0: cmd_o.op = xxh_pkg::OP_MUL_A;
          2'd1: cmd_o.op = xxh_pkg::OP_ROT_B;
          2'd2: cmd_o.op = xxh_pkg::OP_MUL_C;
          default: cmd_o.op = xxh_pkg::OP_MERGE1;
        endcase
      end
      S_LEN: cmd_o.op = xxh_pkg::OP_ADDLEN;
      S_W8: begin
        cmd_o.step = 3'd0;
        case (ph_q)
          2'd0: cmd_o.op = xxh_pkg::OP_MUL_A;
          2'd1: begin
            cmd_o.op = xxh_pkg::OP_ROT_B;
            cmd_o.step = 3'd1;
          end
          2'd2: begin
            cmd_o.op = xxh_pkg::OP_MUL_C;
            cmd_o.step = 3'd1;
          end
          default: cmd_o.op = xxh_pkg::OP_W8;
        endcase
      end
      S_W4: cmd_o.op = ph_q[0] ? xxh_pkg::OP_W4B : xxh_pkg::OP_W4A;
      S_B1: cmd_o.op = ph_q[0] ? xxh_pkg::OP_B1B : xxh_pkg::OP_B1A;
      S_AVAL: cmd_o.op = xxh_pkg::OP_AVAL;
      S_DONE: cmd_o.op = xxh_pkg::OP_DONE;
      default: ;
    endcase
  end

  // Hold a multiply command for its three partial product phases.
  always_comb begin
    case (cmd_o.op)
      xxh_pkg::OP_MUL_A, xxh_pkg::OP_MUL_C, xxh_pkg::OP_MERGE1, xxh_pkg::OP_W8,
      xxh_pkg::OP_W4A, xxh_pkg::OP_W4B, xxh_pkg::OP_B1A, xxh_pkg::OP_B1B:
        mul_op = 1'b1;
      xxh_pkg::OP_AVAL: mul_op = step_q[0];
      default: mul_op = 1'b0;
    endcase
  end

  assign adv = !mul_op || (mph_q == xxh_pkg::MUL_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      ph_q <= '0;
      step_q <= '0;
      words_q <= '0;
      rest_q <= '0;
      mph_q <= '0;
      last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
      if (mul_op) mph_q <= adv ? 2'd0 : mph_q + 2'd1;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            last_q <= last_i;
            idx_q <= '0;
            ph_q <= '0;
            // A full stripe after this word is absorbed first.
            if (stat_i.fill + {2'd0, cnt} >= 6'd32) state_q <= S_ABS;
            else if (last_i) state_q <= S_FIN;
          end
        end
        S_ABS: if (adv) begin
          ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
          if (ph_q == 2'd2) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) state_q <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          idx_q <= '0;
          ph_q <= '0;
          state_q <= stat_i.long_msg ? S_MRG : S_LEN;
        end
        S_MRG: if (adv) begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd3) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) state_q <= S_LEN;
          end
        end
        S_LEN: begin
          words_q <= stat_i.fill[4:3];
          rest_q <= stat_i.fill[2:0];
          idx_q <= '0;
          ph_q <= '0;
          if (stat_i.fill[4:3] != 2'd0) state_q <= S_W8;
          else if (stat_i.fill[2]) state_q <= S_W4;
          else if (stat_i.fill[2:0] != 3'd0) state_q <= S_B1;
          else begin
            step_q <= '0;
            state_q <= S_AVAL;
          end
        end
        S_W8: if (adv) begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd3) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q + 2'd1 == words_q) begin
              if (rest_q[2]) state_q <= S_W4;
              else if (rest_q != 3'd0) state_q <= S_B1;
              else begin
                step_q <= '0;
                state_q <= S_AVAL;
              end
            end
          end
        end
        S_W4: if (adv) begin
          if (ph_q[0]) begin
            ph_q <= '0;
            rest_q <= rest_q - 3'd4;
            if (rest_q == 3'd4) begin
              step_q <= '0;
              state_q <= S_AVAL;
            end else state_q <= S_B1;
          end else ph_q <= ph_q + 2'd1;
        end
        S_B1: if (adv) begin
          if (ph_q[0]) begin
            ph_q <= '0;
            rest_q <= rest_q - 3'd1;
            if (rest_q == 3'd1) begin
              step_q <= '0;
              state_q <= S_AVAL;
            end
          end else ph_q <= ph_q + 2'd1;
        end
        S_AVAL: if (adv) begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd4) state_q <= S_DONE;
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_valid_q || !out_stall) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `XH_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != S_IDLE) |-> in_stall)
  `XH_ASSERT(a_out_after_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `XH_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_q && out_stall) |=> out_valid_q)
endmodule

// ===== hw/rtl/xxhash64_stream_top.sv =====
// Top level of the xxhash64 stream block: controller plus datapath.
// Depends on xxh_pkg, xxh_ctrl, xxh_datapath.
// A non-last word that completes a stripe stalls the input while four lane
// rounds run (every multiply is split into phases on one shared 32x32 multiplier).
// A last word runs merge (long messages only), word folds, tails and avalanche before out_valid rises;
// input stalls until the hash is taken.
// Reset clears control, fill, length and loads the lanes from a zero seed.
module xxhash64_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_value_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  xxh_pkg::cmd_t  cmd;
  xxh_pkg::stat_t stat;
  logic [63:0] seed_q, masked, dp_seed;
  logic [3:0]  cnt;
  logic        fin_load, cfg_load;
  logic [63:0] hash;

  // Config is to be written only while idle; the block does not enforce it; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (cfg_valid) seed_q <= cfg_data;
  end

  // Drop bytes above the count on a short last word.
  always_comb begin
    masked = data_word_i;
    for (int b = 0; b < 8; b++)
      if (4'(b) >= cnt) masked[b*8 +: 8] = 8'd0;
  end

  // Reload lanes on a seed write when no message is open.
  assign cfg_load = cfg_valid && stat.idle_msg;
  assign dp_seed = cfg_load ? cfg_data : seed_q;

  xxh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .last_i,
    .count_i(byte_count_i), .count_o(cnt),
    .out_valid, .out_stall, .stat_i(stat), .cmd_o(cmd), .seed_load_o(fin_load)
  );

  xxh_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .word_i(masked), .count_i(cnt),
    .seed_i(dp_seed), .seed_load_i(fin_load || cfg_load), .stat_o(stat), .hash_o(hash)
  );

  assign hash_value_o = hash;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for xxhash64_stream_top: streams messages as 64-bit
// beats and checks each hash against an XXH64 predictor. Depends on xxh_pkg.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } beat_t;

  // directed row: beat plus optional typed-in hash
  typedef struct {
    beat_t       b;
    logic        known;
    logic [63:0] hash;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] data_word_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] hash_value_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  xxhash64_stream_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_word_i (data_word_i),
    .byte_count_i(byte_count_i),
    .last_i      (last_i),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_value_o(hash_value_o),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: seed, lanes, stripe words, fill and length.
  logic [63:0] seed_q;
  logic [63:0] lanes_q [4];
  logic [63:0] stripe_q [4];
  int unsigned fill_q;
  logic [63:0] length_q;

  logic [63:0] hash_queue [$];
  bit          failed = 1'b0;
  int unsigned cycles = 0;

  function automatic logic [63:0] rol(logic [63:0] v, int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] xround(logic [63:0] acc, logic [63:0] w);
    return rol(acc + w * xxh_pkg::P2, 31) * xxh_pkg::P1;
  endfunction

  function automatic void reload_lanes();
    lanes_q[0] = seed_q + xxh_pkg::P1 + xxh_pkg::P2;
    lanes_q[1] = seed_q + xxh_pkg::P2;
    lanes_q[2] = seed_q;
    lanes_q[3] = seed_q - xxh_pkg::P1;
  endfunction

  function automatic logic [63:0] finish_hash();
    logic [63:0] h;
    logic [63:0] tail;
    int unsigned nwords, rest;
    if (length_q >= 64'd32) begin
      h = rol(lanes_q[0], 1) + rol(lanes_q[1], 7) + rol(lanes_q[2], 12) + rol(lanes_q[3], 18);
      for (int i = 0; i < 4; i++)
        h = (h ^ xround(64'd0, lanes_q[i])) * xxh_pkg::P1 + xxh_pkg::P4;
    end else begin
      h = lanes_q[2] + xxh_pkg::P5;
    end
    h += length_q;
    nwords = (fill_q >> 3) & 3;
    rest = fill_q & 7;
    for (int i = 0; i < nwords; i++)
      h = rol(h ^ xround(64'd0, stripe_q[i]), 27) * xxh_pkg::P1 + xxh_pkg::P4;
    tail = (rest != 0) ? stripe_q[nwords] : 64'd0;
    if (rest >= 4) begin
      h = rol(h ^ ({32'd0, tail[31:0]} * xxh_pkg::P1), 23) * xxh_pkg::P2 + xxh_pkg::P3;
      tail >>= 32;
      rest -= 4;
    end
    while (rest > 0) begin
      h = rol(h ^ ({56'd0, tail[7:0]} * xxh_pkg::P5), 11) * xxh_pkg::P1;
      tail >>= 8;
      rest--;
    end
    h ^= h >> 33;
    h *= xxh_pkg::P2;
    h ^= h >> 29;
    h *= xxh_pkg::P3;
    h ^= h >> 32;
    return h;
  endfunction

  // Advance the predictor by one beat; queue a hash on a last beat.
  function automatic void hash_beat(beat_t b);
    int unsigned n;
    logic [63:0] w;
    n = (!b.last || b.count > 8) ? 8 : b.count;
    w = b.word;
    if (n < 8) w &= (64'd1 << (8 * n)) - 64'd1;
    if (n > 0) begin
      stripe_q[(fill_q >> 3) & 3] = w;
      fill_q += n;
      length_q += n;
      if (fill_q >= 32) begin
        for (int i = 0; i < 4; i++) lanes_q[i] = xround(lanes_q[i], stripe_q[i]);
        fill_q = 0;
      end
    end
    if (b.last) begin
      hash_queue.push_back(finish_hash());
      fill_q = 0;
      length_q = 0;
      reload_lanes();
    end
  endfunction

  // Receiver: stall on its own pattern, check each accepted hash.
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (hash_queue.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, hash_value_o);
        failed = 1'b1;
      end else begin
        if (hash_value_o !== hash_queue[0]) begin
          $display("%0t: hash_value mismatch, expected %h, actual %h",
                   $time, hash_queue[0], hash_value_o);
          failed = 1'b1;
        end
        void'(hash_queue.pop_front());
      end
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  // Send one beat; between bursts usually hold valid low for a random gap.
  task automatic send_beat(beat_t b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    data_word_i <= b.word;
    byte_count_i <= b.count;
    last_i <= b.last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    hash_beat(b);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait for outstanding hashes, then let the block settle.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while (hash_queue.size() != 0) begin
      @(posedge clk_i);
      waited++;
      if (waited > STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the seed while idle; the predictor reloads its lanes too when no message is open.
  task automatic write_seed(logic [63:0] s);
    cfg_valid <= 1'b1;
    cfg_data <= s;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    seed_q = s;
    if (length_q == 0 && fill_q == 0) reload_lanes();
  endtask

  function automatic row_t mk(logic [63:0] w, logic [3:0] c, logic l,
                              logic k = 1'b0, logic [63:0] h = 64'd0);
    row_t r;
    r.b = '{word: w, count: c, last: l};
    r.known = k;
    r.hash = h;
    return r;
  endfunction

  task automatic random_message(int unsigned nbeats);
    beat_t b;
    for (int i = 0; i < nbeats; i++) begin
      b.word = {$urandom, $urandom};
      b.count = $urandom_range(0, 15);
      b.last = (i == nbeats - 1);
      if (b.last && $urandom_range(0, 1) == 0) b.count = $urandom_range(0, 8);
      send_beat(b);
    end
  endtask

  row_t rows [$];
  logic [63:0] seeds [5] = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1,
                             64'h8000_0000_0000_0000, 64'h0};

  initial begin
    seed_q = 64'd0;
    fill_q = 0;
    length_q = 64'd0;
    reload_lanes();
    for (int i = 0; i < 4; i++) stripe_q[i] = 64'd0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message (known XXH64 of nothing, seed 0), byte counts
    // 1..8, oversize count on last, non-last with short count, a stripe
    // filled exactly by the last beat, and a zero-count last after data.
    rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 64'hEF46_DB37_51D8_E999));
    for (int c = 1; c <= 8; c++) rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'(c), 1'b1));
    rows.push_back(mk(64'h0123_4567_89AB_CDEF, 4'd15, 1'b1));
    rows.push_back(mk(64'hAAAA_5555_AAAA_5555, 4'd1, 1'b0));
    rows.push_back(mk(64'h0, 4'd3, 1'b1));
    for (int i = 0; i < 3; i++) rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0));
    rows.push_back(mk(64'h0000_0000_0000_0000, 4'd8, 1'b1));
    for (int i = 0; i < 5; i++) rows.push_back(mk(64'h5555_AAAA_5555_AAAA, 4'd0, 1'b0));
    rows.push_back(mk(64'h0, 4'd0, 1'b1));
    foreach (rows[i]) begin
      send_beat(rows[i].b);
      if (rows[i].known && hash_queue[$] !== rows[i].hash) begin
        $display("%0t: predictor mismatch, expected %h, actual %h",
                 $time, rows[i].hash, hash_queue[$]);
        failed = 1'b1;
      end
    end
    drop_valid();
    drain();

    // Random messages across several seeds; most short, some many stripes.
    foreach (seeds[k]) begin
      write_seed(k == 4 ? {$urandom, $urandom} : seeds[k]);
      for (int m = 0; m < 30; m++) begin
        random_message(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 6));
        stall_mode = (m % 7 == 0) ? 0 : stall_mode;
      end
      drop_valid();
      drain();
    end

    if (!failed) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
